>>> rtl/poi_pkg.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Shared widths, polynomial constants, sequencer states and helpers.
// ----------------------------------------------------------------------------
package poi_pkg;

	// Yaw resolution in bits: one full turn is 2^ANGLE_BITS (range 10 to 24).
	localparam int ANGLE_BITS = 16;
	// Shift that takes rate * time_step down to yaw units.
	localparam int TURN_SHIFT = 32 - ANGLE_BITS;

	localparam int SPEED_W = 16;
	localparam int RATE_W  = 20;
	localparam int STEP_W  = 16;
	localparam int POS_W   = 40;
	localparam int HEAD_W  = 16;

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 18;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Reset value of the time step register (0.1 s in unsigned Q0.16).
	localparam logic [STEP_W-1:0] STEP_RESET = 16'd6554;

	// Quarter-wave sine polynomial coefficients, Q15.
	localparam logic [15:0] SIN_C1 = 16'd51472;
	localparam logic [15:0] SIN_C3 = 16'd21083;
	localparam logic [15:0] SIN_C5 = 16'd2379;
	localparam logic [15:0] QUARTER_TURN = 16'd16384;
	localparam logic [15:0] SIN_MAX = 16'd32767;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TURN,
		S_YAW,
		S_SU,
		S_SU2,
		S_SC5,
		S_SINNER,
		S_SM3,
		S_SSV,
		S_SM5,
		S_SRES,
		S_V1,
		S_V2,
		S_V3,
		S_V4,
		S_V5,
		S_V6,
		S_V7
	} poi_state_t;

	// Top 16 bits of the yaw as a binary angle, zero padded for narrow yaw.
	function automatic logic [HEAD_W-1:0] yaw_top16(input logic [ANGLE_BITS-1:0] y);
		logic [ANGLE_BITS+HEAD_W-1:0] e;
		e = {y, {HEAD_W{1'b0}}};
		return e[ANGLE_BITS+HEAD_W-1 -: HEAD_W];
	endfunction

endpackage

>>> rtl/poi_if.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator channels
// Command, pose and time step channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface poi_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [poi_pkg::SPEED_W-1:0]   linear_x;
	logic signed [poi_pkg::SPEED_W-1:0]   linear_y;
	logic signed [poi_pkg::RATE_W-1:0]    angular_rate;

	modport source (output valid, output linear_x, output linear_y, output angular_rate,
		input ready);
	modport sink (input valid, input linear_x, input linear_y, input angular_rate,
		output ready);
endinterface

interface poi_pose_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [poi_pkg::POS_W-1:0]     pos_x;
	logic signed [poi_pkg::POS_W-1:0]     pos_y;
	logic [poi_pkg::HEAD_W-1:0]           heading;
	logic signed [poi_pkg::SPEED_W-1:0]   speed_echo;
	logic signed [poi_pkg::RATE_W-1:0]    turn_echo;

	modport source (output valid, output pos_x, output pos_y, output heading,
		output speed_echo, output turn_echo, input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading,
		input speed_echo, input turn_echo, output ready);
endinterface

interface poi_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [poi_pkg::STEP_W-1:0]           time_step;

	modport source (output valid, output time_step, input ready);
	modport sink (input valid, input time_step, output ready);
endinterface

>>> rtl/planar_odometry_integrator_unit.sv
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose update from one body velocity command per beat.
// ----------------------------------------------------------------------------
// Steps: turn, half turn on the yaw, sine, cosine, rotation, scaling, output.
// A new command is taken only once the step before it is done; every product of
// the step goes through a single shared 34 x 18 multiplier, one product per cycle.
// Reset (arst_n low, asynchronous): pose and heading clear to zero, the time
// step returns to 0.1 s and both channels come out of reset empty.
// ----------------------------------------------------------------------------
module planar_odometry_integrator_unit (
	input  logic          clk,
	input  logic          arst_n,
	poi_cmd_if.sink       cmd,
	poi_pose_if.source    pose,
	poi_cfg_if.sink       cfg
);

	localparam int AB = poi_pkg::ANGLE_BITS;

	// Sequencer state. The command channel is only open in idle; the pose
	// beat sits in its own output register so a new command can be taken
	// while the previous result still waits on the sink.
	poi_pkg::poi_state_t state_q, state_d;

	// Architectural state and configuration.
	logic [poi_pkg::STEP_W-1:0]         ts_q;
	logic [poi_pkg::POS_W-1:0]          pos_x_q;
	logic [poi_pkg::POS_W-1:0]          pos_y_q;
	logic [AB-1:0]                      yaw_q;
	logic                               cos_sel_q;
	logic                               out_valid_q;

	// Latched command.
	logic signed [poi_pkg::SPEED_W-1:0] vx_q;
	logic signed [poi_pkg::SPEED_W-1:0] vy_q;
	logic signed [poi_pkg::RATE_W-1:0]  rate_q;

	// Working registers of the step.
	logic [AB-1:0]                      half2_q;
	logic [15:0]                        u_q;
	logic                               neg_q;
	logic [15:0]                        u2_q;
	logic [15:0]                        inner_q;
	logic [15:0]                        poly_q;
	logic signed [15:0]                 sin_q;
	logic signed [15:0]                 cos_q;
	logic signed [32:0]                 acc_q;
	logic signed [32:0]                 wx_q;
	logic signed [32:0]                 wy_q;

	// The shared multiplier and its product register.
	logic signed [poi_pkg::MUL_A_W-1:0] mul_a;
	logic signed [poi_pkg::MUL_B_W-1:0] mul_b;
	logic signed [poi_pkg::PROD_W-1:0]  prod_q;

	// Output register.
	logic [poi_pkg::POS_W-1:0]          out_x_q;
	logic [poi_pkg::POS_W-1:0]          out_y_q;
	logic [poi_pkg::HEAD_W-1:0]         out_head_q;
	logic signed [poi_pkg::SPEED_W-1:0] out_speed_q;
	logic signed [poi_pkg::RATE_W-1:0]  out_turn_q;

	// Derived values read straight off registers.
	logic                               cmd_take;
	logic                               finish;
	logic [AB:0]                        full_lo;
	logic [15:0]                        angle;
	logic [14:0]                        mirror;
	logic [16:0]                        mag;
	logic [15:0]                        sat_mag;
	logic signed [15:0]                 trig_val;
	logic [poi_pkg::POS_W-1:0]          delta;
	logic [AB-1:0]                      yaw_end;

	assign cmd.ready = (state_q == poi_pkg::S_IDLE);
	assign cfg.ready = 1'b1;
	assign cmd_take  = cmd.valid && cmd.ready;
	assign finish    = (state_q == poi_pkg::S_V7) && (!out_valid_q || pose.ready);

	// Turn of the step in yaw units. Only the low AB+1 bits matter: the first
	// half is bits AB..1 and the second half is the rest, both modulo the yaw.
	assign full_lo = prod_q[poi_pkg::TURN_SHIFT +: AB+1];

	// Midpoint angle for sine, or a quarter turn on for cosine.
	assign angle  = poi_pkg::yaw_top16(yaw_q) + (cos_sel_q ? poi_pkg::QUARTER_TURN : 16'd0);
	assign mirror = 15'(poi_pkg::QUARTER_TURN) - {1'b0, angle[13:0]};

	// Last product of the polynomial, clamped to just under one, then signed
	// by the half of the circle that the angle falls in.
	assign mag      = prod_q[31:15];
	assign sat_mag  = (mag > 17'(poi_pkg::SIN_MAX)) ? poi_pkg::SIN_MAX : mag[15:0];
	assign trig_val = neg_q ? -$signed(sat_mag) : $signed(sat_mag);

	// World displacement: the scaled velocity product with its fraction
	// dropped by a flooring shift.
	assign delta   = {{(poi_pkg::POS_W - (poi_pkg::PROD_W - 23)){prod_q[poi_pkg::PROD_W-1]}},
		prod_q[poi_pkg::PROD_W-1:23]};
	assign yaw_end = yaw_q + half2_q;

	// Next state and multiplier operand selection.
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			poi_pkg::S_IDLE: begin
				if (cmd.valid) begin
					state_d = poi_pkg::S_TURN;
				end
			end
			poi_pkg::S_TURN: begin
				mul_a   = {{(poi_pkg::MUL_A_W - poi_pkg::RATE_W){rate_q[poi_pkg::RATE_W-1]}}, rate_q};
				mul_b   = {2'b00, ts_q};
				state_d = poi_pkg::S_YAW;
			end
			poi_pkg::S_YAW: begin
				state_d = poi_pkg::S_SU;
			end
			poi_pkg::S_SU: begin
				state_d = poi_pkg::S_SU2;
			end
			poi_pkg::S_SU2: begin
				mul_a   = {18'd0, u_q};
				mul_b   = {2'b00, u_q};
				state_d = poi_pkg::S_SC5;
			end
			poi_pkg::S_SC5: begin
				mul_a   = {18'd0, poi_pkg::SIN_C5};
				mul_b   = {2'b00, prod_q[30:15]};
				state_d = poi_pkg::S_SINNER;
			end
			poi_pkg::S_SINNER: begin
				state_d = poi_pkg::S_SM3;
			end
			poi_pkg::S_SM3: begin
				mul_a   = {18'd0, u2_q};
				mul_b   = {2'b00, inner_q};
				state_d = poi_pkg::S_SSV;
			end
			poi_pkg::S_SSV: begin
				state_d = poi_pkg::S_SM5;
			end
			poi_pkg::S_SM5: begin
				mul_a   = {18'd0, u_q};
				mul_b   = {2'b00, poly_q};
				state_d = poi_pkg::S_SRES;
			end
			poi_pkg::S_SRES: begin
				state_d = cos_sel_q ? poi_pkg::S_V1 : poi_pkg::S_SU;
			end
			poi_pkg::S_V1: begin
				mul_a   = {{18{vx_q[15]}}, vx_q};
				mul_b   = {{2{cos_q[15]}}, cos_q};
				state_d = poi_pkg::S_V2;
			end
			poi_pkg::S_V2: begin
				mul_a   = {{18{vy_q[15]}}, vy_q};
				mul_b   = {{2{sin_q[15]}}, sin_q};
				state_d = poi_pkg::S_V3;
			end
			poi_pkg::S_V3: begin
				mul_a   = {{18{vx_q[15]}}, vx_q};
				mul_b   = {{2{sin_q[15]}}, sin_q};
				state_d = poi_pkg::S_V4;
			end
			poi_pkg::S_V4: begin
				mul_a   = {{18{vy_q[15]}}, vy_q};
				mul_b   = {{2{cos_q[15]}}, cos_q};
				state_d = poi_pkg::S_V5;
			end
			poi_pkg::S_V5: begin
				mul_a   = {wx_q[32], wx_q};
				mul_b   = {2'b00, ts_q};
				state_d = poi_pkg::S_V6;
			end
			poi_pkg::S_V6: begin
				mul_a   = {wy_q[32], wy_q};
				mul_b   = {2'b00, ts_q};
				state_d = poi_pkg::S_V7;
			end
			poi_pkg::S_V7: begin
				if (!out_valid_q || pose.ready) begin
					state_d = poi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = poi_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= poi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control, pose and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q        <= poi_pkg::STEP_RESET;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			yaw_q       <= '0;
			cos_sel_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				ts_q <= cfg.time_step;
			end
			if (state_q == poi_pkg::S_YAW) begin
				yaw_q     <= yaw_q + full_lo[AB:1];
				cos_sel_q <= 1'b0;
			end
			if (state_q == poi_pkg::S_SRES) begin
				cos_sel_q <= 1'b1;
			end
			if (state_q == poi_pkg::S_V6) begin
				pos_x_q <= pos_x_q + delta;
			end
			if (finish) begin
				pos_y_q <= pos_y_q + delta;
				yaw_q   <= yaw_end;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (pose.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers; none of these needs a reset.
	always_ff @(posedge clk) begin
		if (state_q != poi_pkg::S_V7) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd_take) begin
			vx_q   <= cmd.linear_x;
			vy_q   <= cmd.linear_y;
			rate_q <= cmd.angular_rate;
		end
		case (state_q)
			poi_pkg::S_YAW: begin
				half2_q <= full_lo[AB-1:0] - full_lo[AB:1];
			end
			poi_pkg::S_SU: begin
				u_q   <= angle[14] ? {mirror, 1'b0} : {1'b0, angle[13:0], 1'b0};
				neg_q <= angle[15];
			end
			poi_pkg::S_SC5: begin
				u2_q <= prod_q[30:15];
			end
			poi_pkg::S_SINNER: begin
				inner_q <= poi_pkg::SIN_C3 - prod_q[30:15];
			end
			poi_pkg::S_SSV: begin
				poly_q <= poi_pkg::SIN_C1 - prod_q[30:15];
			end
			poi_pkg::S_SRES: begin
				if (cos_sel_q) begin
					cos_q <= trig_val;
				end else begin
					sin_q <= trig_val;
				end
			end
			poi_pkg::S_V2: begin
				acc_q <= prod_q[32:0];
			end
			poi_pkg::S_V3: begin
				wx_q <= acc_q - $signed(prod_q[32:0]);
			end
			poi_pkg::S_V4: begin
				acc_q <= prod_q[32:0];
			end
			poi_pkg::S_V5: begin
				wy_q <= acc_q + $signed(prod_q[32:0]);
			end
			default: begin
			end
		endcase
		if (finish) begin
			out_x_q     <= pos_x_q;
			out_y_q     <= pos_y_q + delta;
			out_head_q  <= poi_pkg::yaw_top16(yaw_end);
			out_speed_q <= vx_q;
			out_turn_q  <= rate_q;
		end
	end

	assign pose.valid      = out_valid_q;
	assign pose.pos_x      = out_x_q;
	assign pose.pos_y      = out_y_q;
	assign pose.heading    = out_head_q;
	assign pose.speed_echo = out_speed_q;
	assign pose.turn_echo  = out_turn_q;

	// A taken command always starts the step with the turn product.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> (state_q == poi_pkg::S_TURN))
		else $error("command beat taken but the step did not start");

	// Finishing a step always leaves a pose beat on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> pose.valid)
		else $error("step finished without a pose beat");

	// The clamped sine and cosine never reach minus one.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == poi_pkg::S_V1) |-> (sin_q != -16'sd32768 && cos_q != -16'sd32768))
		else $error("sine or cosine out of range");

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Drives velocity commands through the command channel and checks every pose
// beat against a cycle-free model of the dead-reckoning update, over several
// time step settings and with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;

	// One velocity command as it crosses the command channel.
	typedef struct {
		logic signed [poi_pkg::SPEED_W-1:0] lin_x;
		logic signed [poi_pkg::SPEED_W-1:0] lin_y;
		logic signed [poi_pkg::RATE_W-1:0]  rate;
	} velocity_cmd_t;

	// One pose beat as it is expected on the pose channel.
	typedef struct {
		logic signed [poi_pkg::POS_W-1:0]   x;
		logic signed [poi_pkg::POS_W-1:0]   y;
		logic [poi_pkg::HEAD_W-1:0]         heading;
		logic signed [poi_pkg::SPEED_W-1:0] speed;
		logic signed [poi_pkg::RATE_W-1:0]  turn;
	} pose_t;

	// Length of the output hold-off used to back the block up.
	localparam int HOLD_CYCLES = 400;
	// Quiet cycles allowed after the last pose beat.
	localparam int SETTLE_CYCLES = 60;
	localparam int PHASE_ITEMS = 280;

	logic clk;
	logic arst_n;

	poi_cmd_if  cmd_ch ();
	poi_pose_if pose_ch ();
	poi_cfg_if  cfg_ch ();

	planar_odometry_integrator_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pose   (pose_ch),
		.cfg    (cfg_ch)
	);

	// Commands waiting to be offered, and poses the block still owes us.
	velocity_cmd_t cmd_backlog[$];
	pose_t         expected_poses[$];

	// Our own copy of the pose state and of the time step register.
	logic [poi_pkg::POS_W-1:0]      est_x;
	logic [poi_pkg::POS_W-1:0]      est_y;
	logic [poi_pkg::ANGLE_BITS-1:0] est_yaw;
	logic [poi_pkg::STEP_W-1:0]     step_setting;

	// Idling controls; the percentages change only between phases while the block is empty.
	int unsigned sender_idle_pct;
	int unsigned stall_pct;
	logic        hold_pending;
	int          hold_left;

	int unsigned cmds_issued;
	int unsigned cmds_taken;
	int unsigned pose_beats;
	int unsigned error_count;
	int unsigned step_settings_used;
	logic        cmd_taken;

	velocity_cmd_t next_cmd;
	velocity_cmd_t seen_cmd;
	pose_t         want;

	// The clock runs from time zero: 12 ns period, first rising edge at 6 ns.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall guard: far beyond the slowest correct run of this stimulus.
	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Model of one integration step.
	// ------------------------------------------------------------------------

	// Sine of a 16-bit binary angle in Q1.15: the top two bits pick the
	// quadrant, the rest is folded onto a quarter wave and fed through the
	// odd polynomial with every product truncated.
	function automatic longint binary_sine(input logic [poi_pkg::HEAD_W-1:0] ang);
		longint off, u, u2, inner, s, mag;
		off = ang[13:0];
		if (ang[14]) begin
			u = (longint'(poi_pkg::QUARTER_TURN) - off) << 1;
		end else begin
			u = off << 1;
		end
		u2 = (u * u) >>> 15;
		inner = longint'(poi_pkg::SIN_C3) - ((longint'(poi_pkg::SIN_C5) * u2) >>> 15);
		s = longint'(poi_pkg::SIN_C1) - ((u2 * inner) >>> 15);
		mag = (u * s) >>> 15;
		if (mag > longint'(poi_pkg::SIN_MAX)) begin
			mag = longint'(poi_pkg::SIN_MAX);
		end
		return ang[15] ? -mag : mag;
	endfunction

	// The heading is the top 16 bits of the yaw, zero padded when narrower.
	function automatic logic [poi_pkg::HEAD_W-1:0] heading_of(
		input logic [poi_pkg::ANGLE_BITS-1:0] y);
		longint wide;
		wide = y;
		if (poi_pkg::ANGLE_BITS >= poi_pkg::HEAD_W) begin
			wide = wide >> (poi_pkg::ANGLE_BITS - poi_pkg::HEAD_W);
		end else begin
			wide = wide << (poi_pkg::HEAD_W - poi_pkg::ANGLE_BITS);
		end
		return wide[poi_pkg::HEAD_W-1:0];
	endfunction

	// Advance our pose by one command and return the beat it must produce.
	// The yaw takes half the turn first, the motion is rotated by that
	// midpoint heading, and the yaw then takes the remainder of the turn.
	function automatic pose_t dead_reckon_step(input velocity_cmd_t c);
		longint ts, turn_full, turn_a, turn_b, sn, cs, wx, wy, dx, dy;
		logic [poi_pkg::HEAD_W-1:0] mid;
		pose_t p;
		ts = longint'(step_setting);
		turn_full = (longint'(c.rate) * ts) >>> poi_pkg::TURN_SHIFT;
		turn_a = turn_full >>> 1;
		turn_b = turn_full - turn_a;
		est_yaw = est_yaw + turn_a[poi_pkg::ANGLE_BITS-1:0];
		mid = heading_of(est_yaw);
		sn = binary_sine(mid);
		cs = binary_sine(mid + poi_pkg::QUARTER_TURN);
		wx = longint'(c.lin_x) * cs - longint'(c.lin_y) * sn;
		wy = longint'(c.lin_x) * sn + longint'(c.lin_y) * cs;
		dx = (wx * ts) >>> 23;
		dy = (wy * ts) >>> 23;
		est_x = est_x + dx[poi_pkg::POS_W-1:0];
		est_y = est_y + dy[poi_pkg::POS_W-1:0];
		est_yaw = est_yaw + turn_b[poi_pkg::ANGLE_BITS-1:0];
		p.x = est_x;
		p.y = est_y;
		p.heading = heading_of(est_yaw);
		p.speed = c.lin_x;
		p.turn = c.rate;
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------

	// Every discrepancy gets one line in the log and is counted.
	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch at pose beat %0d: %s", $realtime, pose_beats, msg);
		error_count++;
	endtask

	// Outputs are sampled on the rising edge, before the block's own updates
	// of that edge land. A pose beat is checked before the command of the
	// same edge is predicted; the two can never belong together anyway.
	always @(posedge clk) begin
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= cmd_ch.valid && cmd_ch.ready;
			if (pose_ch.valid && pose_ch.ready) begin
				pose_beats++;
				if (expected_poses.size() == 0) begin
					report_mismatch("pose beat with no command outstanding");
				end else begin
					want = expected_poses.pop_front();
					if (pose_ch.pos_x !== want.x)
						report_mismatch($sformatf("pos_x %0d, expected %0d",
							pose_ch.pos_x, want.x));
					if (pose_ch.pos_y !== want.y)
						report_mismatch($sformatf("pos_y %0d, expected %0d",
							pose_ch.pos_y, want.y));
					if (pose_ch.heading !== want.heading)
						report_mismatch($sformatf("heading %0d, expected %0d",
							pose_ch.heading, want.heading));
					if (pose_ch.speed_echo !== want.speed)
						report_mismatch($sformatf("speed_echo %0d, expected %0d",
							pose_ch.speed_echo, want.speed));
					if (pose_ch.turn_echo !== want.turn)
						report_mismatch($sformatf("turn_echo %0d, expected %0d",
							pose_ch.turn_echo, want.turn));
				end
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				cmds_taken++;
				seen_cmd.lin_x = cmd_ch.linear_x;
				seen_cmd.lin_y = cmd_ch.linear_y;
				seen_cmd.rate = cmd_ch.angular_rate;
				expected_poses.push_back(dead_reckon_step(seen_cmd));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driving, all on the falling edge
	// ------------------------------------------------------------------------

	// Command driver: a beat on offer stays put until it has been taken; only
	// then may the channel go idle or move on to the next command.
	always @(negedge clk) begin
		if (!cmd_ch.valid || cmd_taken) begin
			if (cmd_backlog.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				next_cmd = cmd_backlog.pop_front();
				cmd_ch.valid <= 1'b1;
				cmd_ch.linear_x <= next_cmd.lin_x;
				cmd_ch.linear_y <= next_cmd.lin_y;
				cmd_ch.angular_rate <= next_cmd.rate;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Pose receiver. Besides random stalls it can hold ready low for a long
	// stretch, counting the stretch itself, so that the block backs up and
	// has to refuse further commands.
	always @(negedge clk) begin
		if (hold_pending && hold_left == 0) begin
			hold_left = HOLD_CYCLES;
			hold_pending = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pose_ch.ready <= 1'b0;
		end else begin
			pose_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------

	task automatic queue_cmd(input longint lx, input longint ly, input longint r);
		velocity_cmd_t c;
		c.lin_x = lx[poi_pkg::SPEED_W-1:0];
		c.lin_y = ly[poi_pkg::SPEED_W-1:0];
		c.rate = r[poi_pkg::RATE_W-1:0];
		cmd_backlog.push_back(c);
		cmds_issued++;
	endtask

	// One of the awkward values of a signed field: both extremes, zero, -1, 1.
	function automatic longint corner_value(input int w);
		case ($urandom_range(4))
			0: return -(longint'(1) << (w - 1));
			1: return (longint'(1) << (w - 1)) - 1;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// Mostly full-range commands, some gentle ones so that the heading creeps
	// through every quadrant, and some built from the field extremes.
	task automatic queue_random_cmd();
		longint lx, ly, r;
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: begin
				lx = $urandom;
				ly = $urandom;
				r = $urandom;
			end
			6, 7: begin
				lx = longint'($urandom_range(511)) - 256;
				ly = longint'($urandom_range(511)) - 256;
				r = longint'($urandom_range(8191)) - 4096;
			end
			default: begin
				lx = corner_value(poi_pkg::SPEED_W);
				ly = corner_value(poi_pkg::SPEED_W);
				r = corner_value(poi_pkg::RATE_W);
			end
		endcase
		queue_cmd(lx, ly, r);
	endtask

	// The time step is only ever written with the block empty.
	task automatic write_time_step(input logic [poi_pkg::STEP_W-1:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.time_step <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		step_setting = v;
		step_settings_used++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Wait until every queued command has been taken and every pose beat has
	// come back, then keep watching for a settling stretch in which any stray
	// beat would be caught.
	task automatic drain();
		@(negedge clk);
		while (cmds_taken != cmds_issued || expected_poses.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Directed corners: the extremes of every field, in combinations that
	// push the rotation and the turn to both signs.
	task automatic queue_corner_cmds();
		queue_cmd(0, 0, 0);
		queue_cmd(32767, 0, 0);
		queue_cmd(-32768, -32768, 524287);
		queue_cmd(0, 32767, -524288);
		queue_cmd(32767, 32767, 524287);
		queue_cmd(-32768, 32767, -524288);
		queue_cmd(-1, -1, -1);
		queue_cmd(1, -1, 1);
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.linear_x = '0;
		cmd_ch.linear_y = '0;
		cmd_ch.angular_rate = '0;
		pose_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.time_step = '0;
		est_x = '0;
		est_y = '0;
		est_yaw = '0;
		step_setting = poi_pkg::STEP_RESET;
		sender_idle_pct = 0;
		stall_pct = 0;
		hold_pending = 1'b0;
		hold_left = 0;
		cmds_issued = 0;
		cmds_taken = 0;
		pose_beats = 0;
		error_count = 0;
		step_settings_used = 1;
		cmd_taken = 1'b0;

		// Reset is released on a falling edge, away from a rising edge.
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed part, first at the reset time step of 0.1 s.
		queue_corner_cmds();
		drain();

		// A zero time step must leave the pose where it is while the echoes
		// still follow the command.
		write_time_step('0);
		queue_cmd(32767, -32768, 524287);
		queue_cmd(-32768, 32767, -524288);
		queue_cmd(1234, -567, 89012);
		drain();

		// The longest step, with the corners again, and a steady turn that
		// walks the heading across quadrant boundaries.
		write_time_step('1);
		queue_corner_cmds();
		for (int i = 0; i < 4; i++) begin
			queue_cmd(16384, -8192, 65536);
		end
		drain();

		// Random phases, each with its own time step and idling pattern.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
					write_time_step('1);
				end
				1: begin
					sender_idle_pct = 80;
					stall_pct = 0;
					write_time_step(16'd1);
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 80;
					write_time_step(poi_pkg::STEP_W'($urandom_range(65535, 1)));
				end
				3: begin
					sender_idle_pct = 38;
					stall_pct = 38;
					write_time_step(poi_pkg::STEP_RESET);
				end
				4: begin
					sender_idle_pct = 0;
					stall_pct = 0;
					write_time_step(poi_pkg::STEP_W'($urandom_range(65535, 1)));
				end
				5: begin
					sender_idle_pct = 38;
					stall_pct = 38;
					write_time_step(16'h8000);
				end
				default: begin
					sender_idle_pct = $urandom_range(80);
					stall_pct = $urandom_range(80);
					write_time_step(poi_pkg::STEP_W'($urandom_range(65535, 1)));
				end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				queue_random_cmd();
			end
			// In the back-to-back phase the receiver goes away for a long
			// stretch while the sender keeps offering commands.
			if (ph == 4) begin
				@(posedge clk);
				hold_pending = 1'b1;
			end
			drain();
		end

		$display("Ran %0d velocity commands and checked %0d pose beats over %0d time step",
			cmds_taken, pose_beats, step_settings_used);
		$display("settings, including a zero step and a %0d-cycle output hold-off.",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
